// ===== design/rtfl_pkg.sv =====
// Shared types, constants and codes of the RGBA transfer function lookup.
// Used by every module of the block; depends on nothing.
package rtfl_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int KEY_W = 16;
    localparam int ADDR_W = 4;
    localparam int DIV_STEPS = 17;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [15:0] t_q16;

    typedef struct packed {
        t_q16 alpha;
        t_q16 blue;
        t_q16 green;
        t_q16 red;
    } t_color;

    typedef struct packed {
        t_key   key;
        t_color color;
    } t_point;

    typedef struct packed {
        logic load_key;
        logic shift_r;
        logic shift_l;
        logic load_color;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        CMD_EVAL   = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_NOTFOUND = 2'd1,
        STS_EMPTY    = 2'd2,
        STS_FULL     = 2'd3
    } t_status;

    localparam logic [1:0] REG_CLAMP = 2'd0;
    localparam logic [1:0] REG_HSV   = 2'd1;
    localparam logic [1:0] REG_WRAP  = 2'd2;

    typedef enum logic [2:0] {
        TS_IDLE,
        TS_SEARCH,
        TS_DECIDE,
        TS_EVAL,
        TS_FIN
    } t_top_state;

    typedef enum logic [2:0] {
        EV_IDLE,
        EV_DIVW,
        EV_DS0,
        EV_DH0,
        EV_DS1,
        EV_DH1,
        EV_MUL
    } t_ev_state;

endpackage

// ===== design/rtfl_cell.sv =====
// One control point of the sorted table: key and color, handed to its neighbors.
// Depends on rtfl_pkg.
module rtfl_cell (
    input  logic               i_clk,
    input  rtfl_pkg::t_cell_ctl i_ctl,
    input  rtfl_pkg::t_point   i_left,
    input  rtfl_pkg::t_point   i_right,
    input  rtfl_pkg::t_point   i_new,
    output rtfl_pkg::t_point   o_point
);
    import rtfl_pkg::*;

    t_point r_point;

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.load_key) begin
            r_point <= i_new;
        end else if (i_ctl.shift_r) begin
            r_point <= i_left;
        end else if (i_ctl.shift_l) begin
            r_point <= i_right;
        end else if (i_ctl.load_color) begin
            r_point.color <= i_new.color;
        end
    end

    assign o_point = r_point;

endmodule

// ===== design/rtfl_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient below 2^17.
// Depends on rtfl_pkg.
module rtfl_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [18:0] i_den,
    output logic        o_done,
    output logic [16:0] o_quot
);
    import rtfl_pkg::*;

    logic [18:0] r_rem;
    logic [16:0] r_lo;
    logic [18:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [19:0] w_trial;
    logic        w_fit;

    assign w_trial = {r_rem, r_lo[16]};
    assign w_fit   = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {4'b0, i_num[31:17]};
            r_lo  <= i_num[16:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_fit ? 19'(w_trial - {1'b0, r_den}) : w_trial[18:0];
            r_lo  <= {r_lo[15:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_lo;

endmodule

// ===== design/rtfl_eval.sv =====
// Interpolation sequencer: weight division, HSV conversion, one shared multiplier.
// Depends on rtfl_pkg and rtfl_div.
module rtfl_eval (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_hsv,
    input  logic             i_wrap,
    input  rtfl_pkg::t_key   i_x,
    input  rtfl_pkg::t_key   i_k0,
    input  rtfl_pkg::t_key   i_k1,
    input  rtfl_pkg::t_color i_c0,
    input  rtfl_pkg::t_color i_c1,
    output logic             o_done,
    output rtfl_pkg::t_color o_color
);
    import rtfl_pkg::*;

    typedef struct packed {
        t_q16 mx;
        t_q16 d;
        t_q16 base;
        logic neg;
        t_q16 diff;
    } t_hsv_pre;

    function automatic t_hsv_pre hsv_pre(input t_color c);
        t_hsv_pre p;
        t_q16     mx;
        t_q16     mn;
        t_q16     pos;
        t_q16     ng;
        mx = c.red;
        mn = c.red;
        if (c.green > mx) mx = c.green;
        if (c.blue > mx) mx = c.blue;
        if (c.green < mn) mn = c.green;
        if (c.blue < mn) mn = c.blue;
        if (c.red == mx) begin
            p.base = 16'd0;
            pos = c.green;
            ng = c.blue;
        end else if (c.green == mx) begin
            p.base = 16'd21845;
            pos = c.blue;
            ng = c.red;
        end else begin
            p.base = 16'd43691;
            pos = c.red;
            ng = c.green;
        end
        p.mx   = mx;
        p.d    = mx - mn;
        p.neg  = pos < ng;
        p.diff = p.neg ? ng - pos : pos - ng;
        return p;
    endfunction

    t_ev_state r_state, n_state;
    logic      r_div_run;
    logic      r_done;
    logic [3:0] r_op;
    t_key      r_x, r_k0, r_k1;
    t_color    r_c0, r_c1;
    t_q16      r_w, r_s0, r_h0, r_s1, r_h1;
    t_q16      r_res [9];

    t_hsv_pre  w_p0, w_p1;
    logic      w_div_start, w_div_done, w_skip;
    logic [31:0] w_num;
    logic [18:0] w_den;
    logic [16:0] w_quot;
    t_q16      w_hue_q;
    t_q16      w_sat_q;

    logic signed [33:0] w_base;
    logic signed [18:0] w_m1;
    logic [16:0]        w_m2;
    logic signed [36:0] w_acc;
    t_q16               w_prod;
    logic [16:0]        w_ha, w_hb;
    logic               w_hwrap;
    logic [18:0]        w_h6;
    t_q16               w_f;
    logic [3:0]         w_last_op;

    assign w_p0 = hsv_pre(r_c0);
    assign w_p1 = hsv_pre(r_c1);

    always_comb begin
        w_num  = '0;
        w_den  = '0;
        w_skip = 1'b0;
        unique case (r_state)
            EV_DIVW: begin
                w_num = {16'(r_x - r_k0), 16'b0};
                w_den = {3'b0, 16'(r_k1 - r_k0)};
            end
            EV_DS0: begin
                w_num  = {w_p0.d, 16'b0};
                w_den  = {3'b0, w_p0.mx};
                w_skip = w_p0.mx == 16'd0;
            end
            EV_DH0: begin
                w_num  = {w_p0.diff, 16'b0};
                w_den  = 19'({w_p0.d, 2'b0}) + 19'({w_p0.d, 1'b0});
                w_skip = w_p0.d == 16'd0;
            end
            EV_DS1: begin
                w_num  = {w_p1.d, 16'b0};
                w_den  = {3'b0, w_p1.mx};
                w_skip = w_p1.mx == 16'd0;
            end
            EV_DH1: begin
                w_num  = {w_p1.diff, 16'b0};
                w_den  = 19'({w_p1.d, 2'b0}) + 19'({w_p1.d, 1'b0});
                w_skip = w_p1.d == 16'd0;
            end
            default: begin
                w_skip = 1'b0;
            end
        endcase
    end

    assign w_div_start = (r_state == EV_DIVW || r_state == EV_DS0 || r_state == EV_DH0 ||
                          r_state == EV_DS1 || r_state == EV_DH1) && !r_div_run && !w_skip;

    rtfl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_sat_q = w_quot[16] ? 16'hFFFF : w_quot[15:0];
    always_comb begin
        if (r_state == EV_DH0) begin
            w_hue_q = w_p0.neg ? w_p0.base - w_quot[15:0] : w_p0.base + w_quot[15:0];
        end else begin
            w_hue_q = w_p1.neg ? w_p1.base - w_quot[15:0] : w_p1.base + w_quot[15:0];
        end
    end

    assign w_last_op = i_hsv ? 4'd8 : 4'd3;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            EV_IDLE: if (i_start) n_state = EV_DIVW;
            EV_DIVW: if (w_div_done) n_state = i_hsv ? EV_DS0 : EV_MUL;
            EV_DS0:  if (w_div_done || w_skip) n_state = EV_DH0;
            EV_DH0:  if (w_div_done || w_skip) n_state = EV_DS1;
            EV_DS1:  if (w_div_done || w_skip) n_state = EV_DH1;
            EV_DH1:  if (w_div_done || w_skip) n_state = EV_MUL;
            EV_MUL:  if (r_op == w_last_op) n_state = EV_IDLE;
            default: n_state = EV_IDLE;
        endcase
    end

    assign w_hwrap = i_wrap && ({1'b0, r_h0} > 17'(r_h1) + 17'd32768 ||
                                {1'b0, r_h1} > 17'(r_h0) + 17'd32768);
    assign w_ha = {w_hwrap && r_h0 <= r_h1, r_h0};
    assign w_hb = {w_hwrap && r_h0 > r_h1, r_h1};

    assign w_h6 = 19'({r_res[2], 2'b0}) + 19'({r_res[2], 1'b0});
    assign w_f  = w_h6[15:0];

    always_comb begin
        w_base = '0;
        w_m1   = '0;
        w_m2   = {1'b0, r_w};
        unique case (r_op)
            4'd0: begin
                if (i_hsv) begin
                    w_base = 34'({r_s0, 16'b0});
                    w_m1   = 19'(signed'({3'b0, r_s1}) - signed'({3'b0, r_s0}));
                end else begin
                    w_base = 34'({r_c0.red, 16'b0});
                    w_m1   = 19'(signed'({3'b0, r_c1.red}) - signed'({3'b0, r_c0.red}));
                end
            end
            4'd1: begin
                if (i_hsv) begin
                    w_base = 34'({w_p0.mx, 16'b0});
                    w_m1   = 19'(signed'({3'b0, w_p1.mx}) - signed'({3'b0, w_p0.mx}));
                end else begin
                    w_base = 34'({r_c0.green, 16'b0});
                    w_m1   = 19'(signed'({3'b0, r_c1.green}) - signed'({3'b0, r_c0.green}));
                end
            end
            4'd2: begin
                if (i_hsv) begin
                    w_base = 34'({w_ha, 16'b0});
                    w_m1   = 19'(signed'({2'b0, w_hb}) - signed'({2'b0, w_ha}));
                end else begin
                    w_base = 34'({r_c0.blue, 16'b0});
                    w_m1   = 19'(signed'({3'b0, r_c1.blue}) - signed'({3'b0, r_c0.blue}));
                end
            end
            4'd3: begin
                w_base = 34'({r_c0.alpha, 16'b0});
                w_m1   = 19'(signed'({3'b0, r_c1.alpha}) - signed'({3'b0, r_c0.alpha}));
            end
            4'd4: begin
                w_m1 = {3'b0, r_res[1]};
                w_m2 = 17'h10000 - 17'(r_res[0]);
            end
            4'd5: begin
                w_m1 = {3'b0, r_res[0]};
                w_m2 = {1'b0, w_f};
            end
            4'd6: begin
                w_m1 = {3'b0, r_res[1]};
                w_m2 = 17'h10000 - 17'(r_res[5]);
            end
            4'd7: begin
                w_m1 = {3'b0, r_res[0]};
                w_m2 = 17'h10000 - 17'(w_f);
            end
            4'd8: begin
                w_m1 = {3'b0, r_res[1]};
                w_m2 = 17'h10000 - 17'(r_res[7]);
            end
            default: begin
                w_m1 = '0;
            end
        endcase
    end

    assign w_acc  = 37'(w_base) + 37'(w_m1 * signed'({1'b0, w_m2})) + 37'sd32768;
    assign w_prod = w_acc[31:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= EV_IDLE;
            r_div_run <= 1'b0;
            r_done    <= 1'b0;
            r_op      <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= r_state == EV_MUL && r_op == w_last_op;
            if (w_div_start) begin
                r_div_run <= 1'b1;
            end else if (w_div_done) begin
                r_div_run <= 1'b0;
            end
            if (r_state == EV_MUL) begin
                r_op <= r_op + 4'd1;
            end else begin
                r_op <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == EV_IDLE && i_start) begin
            r_x  <= i_x;
            r_k0 <= i_k0;
            r_k1 <= i_k1;
            r_c0 <= i_c0;
            r_c1 <= i_c1;
        end
        if (r_state == EV_DIVW && w_div_done) r_w <= w_quot[15:0];
        if (r_state == EV_DS0) r_s0 <= w_skip ? 16'd0 : w_sat_q;
        if (r_state == EV_DH0) r_h0 <= w_skip ? 16'd0 : w_hue_q;
        if (r_state == EV_DS1) r_s1 <= w_skip ? 16'd0 : w_sat_q;
        if (r_state == EV_DH1) r_h1 <= w_skip ? 16'd0 : w_hue_q;
        if (r_state == EV_MUL) begin
            for (int k = 0; k < 9; k++) begin
                if (r_op == 4'(k)) r_res[k] <= w_prod;
            end
        end
    end

    always_comb begin
        o_color.alpha = r_res[3];
        if (!i_hsv) begin
            o_color.red   = r_res[0];
            o_color.green = r_res[1];
            o_color.blue  = r_res[2];
        end else begin
            unique case (w_h6[18:16])
                3'd0: begin
                    o_color.red = r_res[1]; o_color.green = r_res[8]; o_color.blue = r_res[4];
                end
                3'd1: begin
                    o_color.red = r_res[6]; o_color.green = r_res[1]; o_color.blue = r_res[4];
                end
                3'd2: begin
                    o_color.red = r_res[4]; o_color.green = r_res[1]; o_color.blue = r_res[8];
                end
                3'd3: begin
                    o_color.red = r_res[4]; o_color.green = r_res[6]; o_color.blue = r_res[1];
                end
                3'd4: begin
                    o_color.red = r_res[8]; o_color.green = r_res[4]; o_color.blue = r_res[1];
                end
                default: begin
                    o_color.red = r_res[1]; o_color.green = r_res[4]; o_color.blue = r_res[6];
                end
            endcase
        end
    end

    assign o_done = r_done;

endmodule

// ===== design/rgba_transfer_function_lookup.sv =====
// Top level: APB registers, command control, chain of point cells, output register.
// Depends on rtfl_pkg, rtfl_cell, rtfl_eval.
//
// channel  direction  transfer when          payload
// s_*      in         s_tvalid & s_tready    tuser command, tdata key and color
// m_*      out        m_tvalid & m_tready    tdata color and slot, tuser status
// apb      in         psel&penable&pwrite    register write, pready always high
//
// Add, remove, clear and lookups without interpolation write their result from the decide state.
// Interpolation adds a weight division and 4 multiplies; HSV adds up to four more divisions
// and 5 multiplies, all on one divider and one multiplier.
// One item is handled at a time; a waiting result does not block the next transfer in.
// Reset is synchronous and empties the table; the cells themselves are not cleared.
module rgba_transfer_function_lookup (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [79:0]               s_tdata,  // key, red, green, blue, alpha
    input  logic [1:0]                s_tuser,  // command
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [71:0]               m_tdata,  // red, green, blue, alpha, slot, zero pad
    output logic [1:0]                m_tuser,  // status
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [rtfl_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import rtfl_pkg::*;

    t_top_state r_state, n_state;
    logic       r_clamp, r_hsv, r_wrap;
    logic [CNT_W-1:0] r_count;
    t_cmd       r_cmd;
    t_key       r_x;
    t_color     r_cin;

    logic [CNT_W-1:0] r_idx;
    logic       r_found, r_none;
    t_color     r_ci, r_cim1, r_clast;
    t_key       r_ki, r_kim1;

    logic       r_out_valid;
    t_color     r_out_color;
    logic [CNT_W-1:0] r_out_slot;
    t_status    r_out_status;

    t_point     w_pt [DEPTH];
    t_cell_ctl  w_ctl [DEPTH];
    logic [DEPTH-1:0] w_valid, w_gt, w_eq, w_sel, w_last;
    logic [IDX_W-1:0] w_idx_or;
    t_color     w_ci, w_cim1, w_clast;
    t_key       w_ki, w_kim1;

    logic       w_accept, w_out_free, w_write;
    logic       w_ins_go, w_rep_go, w_rem_go, w_ev_start, w_ev_done, w_need_interp;
    t_color     w_res_color, w_ev_color;
    logic [CNT_W-1:0] w_res_slot;
    t_status    w_res_status;

    assign pready   = 1'b1;
    assign s_tready = r_state == TS_IDLE;
    assign w_accept = s_tvalid && s_tready;
    assign w_out_free = !r_out_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp <= 1'b1;
            r_hsv   <= 1'b0;
            r_wrap  <= 1'b1;
        end else if (psel && penable && pwrite) begin
            if (paddr[3:2] == REG_CLAMP) r_clamp <= pwdata[0];
            if (paddr[3:2] == REG_HSV)   r_hsv   <= pwdata[0];
            if (paddr[3:2] == REG_WRAP)  r_wrap  <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[3:2] == REG_CLAMP) prdata = {31'b0, r_clamp};
        if (paddr[3:2] == REG_HSV)   prdata = {31'b0, r_hsv};
        if (paddr[3:2] == REG_WRAP)  prdata = {31'b0, r_wrap};
    end

    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        t_point w_left, w_right;
        assign w_left  = (j == 0) ? w_pt[j] : w_pt[(j == 0) ? 0 : j - 1];
        assign w_right = (j == DEPTH - 1) ? w_pt[j] : w_pt[(j == DEPTH - 1) ? j : j + 1];
        assign w_valid[j] = CNT_W'(j) < r_count;
        assign w_gt[j] = w_valid[j] && r_x > w_pt[j].key;
        assign w_eq[j] = w_valid[j] && r_x == w_pt[j].key;
        if (j == 0) begin : g_first
            assign w_sel[j] = w_valid[j] && !w_gt[j];
        end else begin : g_rest
            assign w_sel[j] = w_valid[j] && w_gt[j-1] && !w_gt[j];
        end
        if (j == DEPTH - 1) begin : g_end
            assign w_last[j] = w_valid[j];
        end else begin : g_mid
            assign w_last[j] = w_valid[j] && !w_valid[j+1];
        end
        assign w_ctl[j].load_key   = w_ins_go && CNT_W'(j) == r_idx;
        assign w_ctl[j].shift_r    = w_ins_go && CNT_W'(j) > r_idx;
        assign w_ctl[j].shift_l    = w_rem_go && CNT_W'(j) >= r_idx;
        assign w_ctl[j].load_color = (w_ins_go || w_rep_go) && CNT_W'(j) == r_idx;

        rtfl_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[j]),
            .i_left  (w_left),
            .i_right (w_right),
            .i_new   ({r_x, r_cin}),
            .o_point (w_pt[j])
        );
    end

    always_comb begin
        w_idx_or = '0;
        w_ci     = '0;
        w_cim1   = '0;
        w_clast  = '0;
        w_ki     = '0;
        w_kim1   = '0;
        for (int j = 0; j < DEPTH; j++) begin
            if (w_sel[j]) begin
                w_idx_or = w_idx_or | IDX_W'(j);
                w_ci     = w_ci | w_pt[j].color;
                w_ki     = w_ki | w_pt[j].key;
                if (j > 0) begin
                    w_cim1 = w_cim1 | w_pt[(j > 0) ? j - 1 : 0].color;
                    w_kim1 = w_kim1 | w_pt[(j > 0) ? j - 1 : 0].key;
                end
            end
            if (w_last[j]) w_clast = w_clast | w_pt[j].color;
        end
    end

    assign w_need_interp = r_cmd == CMD_EVAL && r_count != '0 && !r_none && !r_found &&
                           r_idx != '0;

    always_comb begin
        w_res_color  = '0;
        w_res_slot   = '0;
        w_res_status = STS_OK;
        unique case (r_cmd)
            CMD_EVAL: begin
                priority if (r_count == '0) begin
                    w_res_status = STS_EMPTY;
                end else if (r_none) begin
                    if (r_clamp) w_res_color = r_clast;
                end else if (r_found) begin
                    w_res_color = r_ci;
                end else if (r_idx == '0) begin
                    if (r_clamp) w_res_color = r_ci;
                end else begin
                    w_res_color = '0;
                end
            end
            CMD_ADD: begin
                if (!r_found && r_count == CNT_W'(DEPTH)) begin
                    w_res_status = STS_FULL;
                end else begin
                    w_res_slot = r_idx;
                end
            end
            CMD_REMOVE: begin
                if (r_found) begin
                    w_res_slot = r_idx;
                end else begin
                    w_res_status = STS_NOTFOUND;
                end
            end
            default: begin
                w_res_status = STS_OK;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        w_write    = 1'b0;
        w_ev_start = 1'b0;
        w_ins_go   = 1'b0;
        w_rep_go   = 1'b0;
        w_rem_go   = 1'b0;
        unique case (r_state)
            TS_IDLE: begin
                if (w_accept) n_state = TS_SEARCH;
            end
            TS_SEARCH: begin
                n_state = TS_DECIDE;
            end
            TS_DECIDE: begin
                if (w_need_interp) begin
                    w_ev_start = 1'b1;
                    n_state    = TS_EVAL;
                end else if (w_out_free) begin
                    w_write  = 1'b1;
                    n_state  = TS_IDLE;
                    w_rep_go = r_cmd == CMD_ADD && r_found;
                    w_ins_go = r_cmd == CMD_ADD && !r_found && r_count != CNT_W'(DEPTH);
                    w_rem_go = r_cmd == CMD_REMOVE && r_found;
                end
            end
            TS_EVAL: begin
                if (w_ev_done) n_state = TS_FIN;
            end
            TS_FIN: begin
                if (w_out_free) begin
                    w_write = 1'b1;
                    n_state = TS_IDLE;
                end
            end
            default: n_state = TS_IDLE;
        endcase
    end

    rtfl_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ev_start),
        .i_hsv   (r_hsv),
        .i_wrap  (r_wrap),
        .i_x     (r_x),
        .i_k0    (r_kim1),
        .i_k1    (r_ki),
        .i_c0    (r_cim1),
        .i_c1    (r_ci),
        .o_done  (w_ev_done),
        .o_color (w_ev_color)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= TS_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_write) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_write && r_state == TS_DECIDE) begin
                if (r_cmd == CMD_CLEAR) r_count <= '0;
                if (w_ins_go) r_count <= r_count + CNT_W'(1);
                if (w_rem_go) r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= t_cmd'(s_tuser);
            r_x   <= s_tdata[15:0];
            r_cin <= s_tdata[79:16];
        end
        if (r_state == TS_SEARCH) begin
            r_none  <= !(|w_sel);
            r_found <= |(w_sel & w_eq);
            r_idx   <= (|w_sel) ? CNT_W'(w_idx_or) : r_count;
            r_ci    <= w_ci;
            r_cim1  <= w_cim1;
            r_clast <= w_clast;
            r_ki    <= w_ki;
            r_kim1  <= w_kim1;
        end
        if (w_write) begin
            r_out_color  <= (r_state == TS_FIN) ? w_ev_color : w_res_color;
            r_out_slot   <= (r_state == TS_FIN) ? '0 : w_res_slot;
            r_out_status <= (r_state == TS_FIN) ? STS_OK : w_res_status;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {1'b0, r_out_slot, r_out_color};
    assign m_tuser  = r_out_status;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("point count above table depth");

    a_accept_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == TS_SEARCH)
        else $error("transfer in not followed by search");

    a_done_in_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ev_done |-> r_state == TS_EVAL)
        else $error("interpolation finished outside eval state");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == TS_IDLE |=> $stable(r_count))
        else $error("table changed while idle");

endmodule
